// ===== rtl/swvc_pkg.sv =====
// ----------------------------------------------------------------------------
// swvc_pkg
// Shared types and constants for the single-wire voice command sender.
// ----------------------------------------------------------------------------
package swvc_pkg;

  localparam int KindW  = 2;
  localparam int CodeW  = 8;
  localparam int PhaseW = 4;
  localparam int TickW  = 8;
  localparam int BitW   = 6;
  localparam int BusyW  = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
  localparam logic [KindW-1:0] KIND_PLAY  = 2'd1;
  localparam logic [KindW-1:0] KIND_POWER = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_VOICE_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BYPASS_CODE     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_START_TICKS     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIT_TICKS       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH_TICKS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH_TICKS = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BUSY_LIMIT      = 3'd6;

  localparam logic [TickW-1:0] START_TICKS_RST = 8'd49;
  localparam logic [BitW-1:0]  BIT_TICKS_RST   = 6'd15;
  localparam logic [BitW-1:0]  ONE_HIGH_RST    = 6'd12;
  localparam logic [BitW-1:0]  ZERO_HIGH_RST   = 6'd4;
  localparam logic [BusyW-1:0] BUSY_LIMIT_RST  = 10'd199;
  localparam logic [PhaseW-1:0] LAST_BIT_PHASE = 4'd7;

  typedef struct packed {
    logic             voice_enable;
    logic [CodeW-1:0] bypass_code;
    logic [TickW-1:0] start_ticks;
    logic [BitW-1:0]  bit_ticks;
    logic [BitW-1:0]  one_high_ticks;
    logic [BitW-1:0]  zero_high_ticks;
    logic [BusyW-1:0] busy_limit;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CodeW-1:0] code;
    logic             power_value;
    logic             busy_pin;
  } item_t;

  typedef struct packed {
    logic              line_level;
    logic              power_state;
    logic              send_active;
    logic [PhaseW-1:0] bit_phase;
    logic [TickW-1:0]  tick_count;
    logic [CodeW-1:0]  shift_code;
    logic [CodeW-1:0]  saved_code;
    logic              frame_done;
    logic              check_pending;
    logic [BusyW-1:0]  busy_count;
  } state_t;

  typedef struct packed {
    logic data_line;
    logic power_on;
    logic sending;
    logic checking;
    logic resent;
  } result_t;

endpackage

// ===== rtl/single_wire_voice_command_sender.sv =====
// ----------------------------------------------------------------------------
// single_wire_voice_command_sender
// Drives a single-wire voice chip: play, power and tick requests in, one
// line/status result out per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        request    in_valid/in_stall    kind, code, power_value, busy_pin
// out       result     out_valid/out_stall  data_line, power_on, sending,
//                                           checking, resent
// cfg       write      cfg_wr_en            cfg_index, cfg_wdata
//
// Each request is registered, updates the frame state and its result is
// registered, and one request is taken every cycle while the result is not
// stalled. Reset is synchronous and active low. A stalled result holds
// the pipeline; the input register still accepts while it is empty.
// ----------------------------------------------------------------------------
module single_wire_voice_command_sender (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [swvc_pkg::KindW-1:0]     in_kind,
  input  logic [swvc_pkg::CodeW-1:0]     in_code,
  input  logic                           in_power_value,
  input  logic                           in_busy_pin,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_data_line,
  output logic                           out_power_on,
  output logic                           out_sending,
  output logic                           out_checking,
  output logic                           out_resent,
  input  logic                           cfg_wr_en,
  input  logic [swvc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [swvc_pkg::CfgDataW-1:0]  cfg_wdata
);
  import swvc_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  result_t res;
  result_t res_r;
  logic    res_valid_r;
  logic    advance;

  assign advance  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;

  swvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swvc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind        <= in_kind;
      item_r.code        <= in_code;
      item_r.power_value <= in_power_value;
      item_r.busy_pin    <= in_busy_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_data_line = res_r.data_line;
  assign out_power_on  = res_r.power_on;
  assign out_sending   = res_r.sending;
  assign out_checking  = res_r.checking;
  assign out_resent    = res_r.resent;

endmodule

// ===== rtl/swvc_cfg.sv =====
// ----------------------------------------------------------------------------
// swvc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module swvc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [swvc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [swvc_pkg::CfgDataW-1:0]    cfg_wdata,
  output swvc_pkg::cfg_t                   cfg
);
  import swvc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voice_enable    <= 1'b1;
      cfg_r.bypass_code     <= '0;
      cfg_r.start_ticks     <= START_TICKS_RST;
      cfg_r.bit_ticks       <= BIT_TICKS_RST;
      cfg_r.one_high_ticks  <= ONE_HIGH_RST;
      cfg_r.zero_high_ticks <= ZERO_HIGH_RST;
      cfg_r.busy_limit      <= BUSY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VOICE_ENABLE:    cfg_r.voice_enable    <= cfg_wdata[0];
        REG_BYPASS_CODE:     cfg_r.bypass_code     <= cfg_wdata[CodeW-1:0];
        REG_START_TICKS:     cfg_r.start_ticks     <= cfg_wdata[TickW-1:0];
        REG_BIT_TICKS:       cfg_r.bit_ticks       <= cfg_wdata[BitW-1:0];
        REG_ONE_HIGH_TICKS:  cfg_r.one_high_ticks  <= cfg_wdata[BitW-1:0];
        REG_ZERO_HIGH_TICKS: cfg_r.zero_high_ticks <= cfg_wdata[BitW-1:0];
        REG_BUSY_LIMIT:      cfg_r.busy_limit      <= cfg_wdata[BusyW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/swvc_core.sv =====
// ----------------------------------------------------------------------------
// swvc_core
// Frame state and the single-pass update applied for each request.
// ----------------------------------------------------------------------------
module swvc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  swvc_pkg::item_t   item,
  input  swvc_pkg::cfg_t    cfg,
  output swvc_pkg::result_t result
);
  import swvc_pkg::*;

  state_t st_r;
  state_t st_nxt;
  logic   resent;
  logic   play;
  logic [CodeW-1:0] play_code;
  logic [BitW-1:0]  drop;
  logic [BusyW-1:0] busy_inc;

  always_comb begin
    st_nxt    = st_r;
    resent    = 1'b0;
    play      = 1'b0;
    play_code = item.code;
    drop      = st_r.shift_code[0] ? cfg.one_high_ticks : cfg.zero_high_ticks;
    busy_inc  = st_r.busy_count + 10'd1;

    case (item.kind)
      KIND_TICK: begin
        if (st_r.send_active) begin
          if (st_r.bit_phase == '0) begin
            if (st_r.tick_count > cfg.start_ticks) begin
              st_nxt.tick_count = '0;
              st_nxt.bit_phase  = 4'd1;
              st_nxt.line_level = 1'b1;
            end
          end else begin
            if (st_r.tick_count == {2'b00, drop}) begin
              st_nxt.line_level = 1'b0;
            end
            if (st_r.tick_count > {2'b00, cfg.bit_ticks}) begin
              st_nxt.tick_count = '0;
              st_nxt.shift_code = {1'b0, st_r.shift_code[CodeW-1:1]};
              st_nxt.line_level = 1'b1;
              if (st_r.bit_phase > LAST_BIT_PHASE) begin
                st_nxt.send_active = 1'b0;
                st_nxt.frame_done  = 1'b1;
                st_nxt.bit_phase   = 4'd1;
              end else begin
                st_nxt.bit_phase = st_r.bit_phase + 4'd1;
              end
            end
          end
          st_nxt.tick_count = st_nxt.tick_count + 8'd1;
        end else if (st_r.frame_done && st_r.check_pending) begin
          if (!item.busy_pin) begin
            st_nxt.frame_done    = 1'b0;
            st_nxt.busy_count    = '0;
            st_nxt.check_pending = 1'b0;
          end else if (busy_inc > cfg.busy_limit) begin
            st_nxt.busy_count = '0;
            st_nxt.frame_done = 1'b0;
            play              = 1'b1;
            play_code         = st_r.saved_code;
            resent            = 1'b1;
          end else begin
            st_nxt.busy_count = busy_inc;
          end
        end
      end
      KIND_PLAY: begin
        play = 1'b1;
      end
      KIND_POWER: begin
        st_nxt.power_state = item.power_value;
      end
      default: ;
    endcase

    if (play) begin
      st_nxt.power_state = 1'b1;
      if (cfg.voice_enable || play_code == cfg.bypass_code) begin
        st_nxt.shift_code    = play_code;
        st_nxt.saved_code    = play_code;
        st_nxt.tick_count    = '0;
        st_nxt.bit_phase     = '0;
        st_nxt.send_active   = 1'b1;
        st_nxt.check_pending = 1'b1;
        st_nxt.line_level    = 1'b0;
      end
    end

    // The timeout replay never gets a busy check of its own.
    if (resent) begin
      st_nxt.check_pending = 1'b0;
    end
  end

  // The line idles high; every other state field resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= {1'b1, {($bits(state_t) - 1){1'b0}}};
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  assign result.data_line = st_nxt.line_level;
  assign result.power_on  = st_nxt.power_state;
  assign result.sending   = st_nxt.send_active;
  assign result.checking  = st_nxt.check_pending;
  assign result.resent    = resent;

endmodule
